### sv/url_path_normalizer_unit_macros.svh
// Assertion macros for the URL path normalizer checker.
`ifndef URL_PATH_NORMALIZER_UNIT_MACROS_SVH
`define URL_PATH_NORMALIZER_UNIT_MACROS_SVH

// Checked out of reset only.
`define UPN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked during reset too.
`define UPN_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/upn_pkg.sv
// Shared constants, types and controller codes of the URL path normalizer.
package upn_pkg;

	localparam int BUF_DEPTH_DEF = 1024;

	localparam logic [7:0]  CH_NUL        = 8'h00;
	localparam logic [7:0]  CH_SPACE      = 8'h20;
	localparam logic [7:0]  CH_DOT        = 8'h2E;
	localparam logic [7:0]  CH_SLASH      = 8'h2F;
	localparam logic [15:0] PAIR_DOTDOT   = {CH_DOT, CH_DOT};
	localparam logic [15:0] PAIR_SLASHDOT = {CH_SLASH, CH_DOT};

	typedef enum logic {
		PH_SKIP,
		PH_PATH
	} upn_phase_t;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} upn_state_t;

	typedef struct packed {
		logic start_walk;
		logic walk_step;
		logic commit;
		logic from_walk;
	} upn_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_fin;
	} upn_sts_t;

endpackage

### sv/upn_outq.sv
// Two-entry result queue between the datapath and the output channel.
module upn_outq #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] dout
);
	localparam logic [1:0] CNT_FULL = 2'd2;

	logic [DW-1:0] ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign out_valid = cnt_q != 2'd0;
	assign space     = cnt_q != CNT_FULL;
	assign pop       = out_valid && out_ready;
	assign dout      = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= din;
	end

endmodule

### sv/upn_dp.sv
// Datapath: path state, normalized path buffer and the segment walk-back.
module upn_dp #(
	parameter int BUF_DEPTH = upn_pkg::BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH),
	localparam int LW = $clog2(BUF_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       ch,
	input  upn_pkg::upn_cmd_t cmd,
	output upn_pkg::upn_sts_t sts,
	output logic             r_en,
	output logic [AW-1:0]    r_pos,
	output logic [7:0]       r_char,
	output logic             r_lead,
	output logic [LW-1:0]    r_len,
	output logic             r_done,
	output logic             r_ovf
);
	import upn_pkg::*;

	localparam logic [LW-1:0] DEPTH_L = LW'(BUF_DEPTH);

	logic [7:0]    mem [BUF_DEPTH];
	logic [7:0]    rdata_q;

	logic [LW-1:0] out_index_q;
	logic [LW-1:0] seg_q;
	logic [15:0]   last2_q;
	upn_phase_t    phase_q;
	logic          ovf_q;
	logic [7:0]    ch_q;
	logic [AW-1:0] walk_o_q;

	logic [LW-1:0] n_out;
	logic [LW-1:0] n_seg;
	logic [15:0]   n_last;
	upn_phase_t    n_phase;
	logic          n_ovf;

	logic [7:0]    cur_ch;
	logic [LW-1:0] tok;
	logic          is_term;
	logic          dotdot;
	logic          dotseg;
	logic [LW-1:0] base;
	logic [LW-1:0] o_rew;
	logic          hit;
	logic [AW-1:0] walk_nxt;
	logic [AW-1:0] seg_m1;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_wa;

	assign cur_ch   = cmd.from_walk ? ch_q : ch;
	assign tok      = out_index_q - seg_q;
	assign is_term  = (cur_ch == CH_SLASH) || (cur_ch == CH_NUL);
	assign dotdot   = is_term && (tok == LW'(3)) && (last2_q == PAIR_DOTDOT);
	assign dotseg   = is_term && !dotdot &&
		((tok == LW'(1)) || (last2_q == PAIR_SLASHDOT));

	assign hit      = rdata_q == CH_SLASH;
	assign walk_nxt = walk_o_q - AW'(1);
	assign seg_m1   = AW'(seg_q - LW'(1));
	assign rd_addr  = cmd.start_walk ? seg_m1 : walk_nxt;
	assign o_rew    = (cmd.from_walk && hit) ? LW'(walk_o_q) : '0;

	assign sts.need_walk = (phase_q == PH_PATH) && dotdot && (seg_q > LW'(1));
	assign sts.walk_fin  = hit || (walk_nxt == '0);

	always_comb begin
		n_out   = out_index_q;
		n_seg   = seg_q;
		n_last  = last2_q;
		n_phase = phase_q;
		n_ovf   = ovf_q;
		r_en    = 1'b0;
		r_pos   = '0;
		r_char  = 8'h00;
		r_lead  = 1'b0;
		r_done  = 1'b0;
		mem_we  = 1'b0;
		mem_wa  = '0;
		base    = out_index_q;
		if (phase_q == PH_SKIP) begin
			if (cur_ch == CH_SPACE) begin
				n_out = out_index_q;
			end else if (cur_ch == CH_NUL) begin
				r_lead = 1'b1;
				r_done = 1'b1;
				n_out  = LW'(1);
			end else if (cur_ch == CH_SLASH) begin
				r_en    = 1'b1;
				r_char  = cur_ch;
				mem_we  = 1'b1;
				n_out   = LW'(1);
				n_seg   = '0;
				n_last  = {CH_NUL, CH_SLASH};
				n_phase = PH_PATH;
			end else begin
				r_lead  = 1'b1;
				r_en    = 1'b1;
				r_pos   = AW'(1);
				r_char  = cur_ch;
				mem_we  = 1'b1;
				mem_wa  = AW'(1);
				n_out   = LW'(2);
				n_seg   = '0;
				n_last  = {CH_SLASH, cur_ch};
				n_phase = PH_PATH;
			end
		end else begin
			if (dotdot)
				base = o_rew;
			else if (dotseg)
				base = seg_q;
			if ((dotdot || dotseg) && (cur_ch == CH_NUL))
				base = (base >= DEPTH_L) ? DEPTH_L : base + LW'(1);
			if (is_term)
				n_seg = base;
			n_out = base;
			if (cur_ch == CH_NUL) begin
				r_done = 1'b1;
			end else begin
				if (base < DEPTH_L) begin
					r_en   = 1'b1;
					r_pos  = base[AW-1:0];
					r_char = cur_ch;
					mem_we = 1'b1;
					mem_wa = base[AW-1:0];
					n_out  = base + LW'(1);
				end else begin
					n_ovf = 1'b1;
				end
				n_last = {last2_q[7:0], cur_ch};
			end
		end
		r_len = n_out;
		r_ovf = n_ovf;
		if (r_done) begin
			n_out   = '0;
			n_seg   = '0;
			n_last  = '0;
			n_phase = PH_SKIP;
			n_ovf   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_index_q <= '0;
			seg_q       <= '0;
			last2_q     <= '0;
			phase_q     <= PH_SKIP;
			ovf_q       <= 1'b0;
		end else if (cmd.commit) begin
			out_index_q <= n_out;
			seg_q       <= n_seg;
			last2_q     <= n_last;
			phase_q     <= n_phase;
			ovf_q       <= n_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_walk) begin
			ch_q     <= ch;
			walk_o_q <= seg_m1;
		end else if (cmd.walk_step) begin
			walk_o_q <= walk_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we)
			mem[mem_wa] <= r_char;
		rdata_q <= mem[rd_addr];
	end

endmodule

### sv/upn_ctrl.sv
// Controller: input handshake and sequencing of the '..' walk-back.
module upn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              q_space,
	input  upn_pkg::upn_sts_t sts,
	output upn_pkg::upn_cmd_t cmd
);
	import upn_pkg::*;

	upn_state_t state_q;
	upn_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = q_space;
				if (in_valid && q_space) begin
					if (sts.need_walk) begin
						cmd.start_walk = 1'b1;
						state_d        = S_WALK;
					end else begin
						cmd.commit = 1'b1;
					end
				end
			end
			S_WALK: begin
				cmd.from_walk = 1'b1;
				if (sts.walk_fin) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### sv/url_path_normalizer_unit.sv
// Top level of the URL path normalizer: controller, datapath and result queue.
// Takes one path byte per item (0 ends the path) and returns one result per item.
// A byte is committed as it is taken, except a '/' or terminating 0 that closes a
// '..' segment whose '/' lies past position 1: that byte first walks the buffer backward
// to the previous '/', one entry per cycle through the buffer's single registered
// read port, and is committed when the walk ends. A two-entry result queue lets
// new bytes be taken while results wait. No clearing pass follows reset.
module url_path_normalizer_unit #(
	parameter int BUF_DEPTH = upn_pkg::BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH),
	localparam int LW = $clog2(BUF_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    ch,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          wr_en,
	output logic [AW-1:0] wr_pos,
	output logic [7:0]    wr_char,
	output logic          lead_slash,
	output logic [LW-1:0] path_len,
	output logic          done_res,
	output logic          overflow
);
	import upn_pkg::*;

	localparam int DW = AW + LW + 12;

	upn_cmd_t      cmd;
	upn_sts_t      sts;
	logic          q_space;
	logic          r_en;
	logic [AW-1:0] r_pos;
	logic [7:0]    r_char;
	logic          r_lead;
	logic [LW-1:0] r_len;
	logic          r_done;
	logic          r_ovf;
	logic [DW-1:0] q_din;
	logic [DW-1:0] q_dout;

	upn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.q_space  (q_space),
		.sts      (sts),
		.cmd      (cmd)
	);

	upn_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (ch),
		.cmd    (cmd),
		.sts    (sts),
		.r_en   (r_en),
		.r_pos  (r_pos),
		.r_char (r_char),
		.r_lead (r_lead),
		.r_len  (r_len),
		.r_done (r_done),
		.r_ovf  (r_ovf)
	);

	assign q_din = {r_en, r_pos, r_char, r_lead, r_len, r_done, r_ovf};

	upn_outq #(
		.DW (DW)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.commit),
		.din       (q_din),
		.space     (q_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (q_dout)
	);

	assign {wr_en, wr_pos, wr_char, lead_slash, path_len, done_res, overflow} = q_dout;

endmodule

### sv/upn_checker.sv
// Port-level checker for the URL path normalizer and its bind.
`include "url_path_normalizer_unit_macros.svh"

module upn_checker #(
	parameter int BUF_DEPTH = upn_pkg::BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH),
	localparam int LW = $clog2(BUF_DEPTH + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic [7:0]    ch,
	input logic          out_valid,
	input logic          out_ready,
	input logic          wr_en,
	input logic [AW-1:0] wr_pos,
	input logic          lead_slash,
	input logic [LW-1:0] path_len,
	input logic          done_res
);
	import upn_pkg::*;

	logic lead_ok;

	// a leading slash only comes with a one- or two-byte path
	assign lead_ok = !lead_slash || (path_len == LW'(1)) || (path_len == LW'(2));

	`UPN_ASSERT_RST(a_no_item_in_reset, !arst_n |-> !out_valid, "result item during reset")
	`UPN_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "result item dropped")
	`UPN_ASSERT(a_done_no_write, out_valid && done_res |-> !wr_en && lead_ok, "bad end item")
	`UPN_ASSERT(a_len_follows_write, out_valid && wr_en |-> path_len == LW'(wr_pos) + LW'(1), "len mismatch")
	`UPN_ASSERT(a_space_one_cycle, in_valid && in_ready && ch == CH_SPACE |=> out_valid, "space slow")

endmodule

bind url_path_normalizer_unit upn_checker #(.BUF_DEPTH(BUF_DEPTH)) u_upn_checker (.*);

### tb/sv/tb.sv
// Testbench for url_path_normalizer_unit: queued path bytes, bit-exact prediction, checking.
`timescale 1ns / 1ps

module tb;
	import upn_pkg::*;

	localparam int DEPTH = BUF_DEPTH_DEF;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int RAND_TARGET = 1750;
	localparam int LONG_AT = 500;
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 250;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic [1:0] RX_FREE   = 2'd0;
	localparam logic [1:0] RX_RANDOM = 2'd1;
	localparam logic [1:0] RX_SPARSE = 2'd2;

	typedef struct {
		logic [7:0] ch;
		bit         drain;
	} pend_item_t;

	typedef struct packed {
		logic          wr_en;
		logic [AW-1:0] wr_pos;
		logic [7:0]    wr_char;
		logic          lead_slash;
		logic [LW-1:0] path_len;
		logic          done_res;
		logic          overflow;
	} path_res_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b1;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [7:0]    ch = 8'h00;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic          wr_en;
	logic [AW-1:0] wr_pos;
	logic [7:0]    wr_char;
	logic          lead_slash;
	logic [LW-1:0] path_len;
	logic          done_res;
	logic          overflow;

	pend_item_t pend_q[$];
	path_res_t  expected_q[$];
	int         err_cnt = 0;
	int         n_items = 0;
	int         burst_left = 1;
	int         gap_left = 0;
	int         res_cnt = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	logic [1:0] rx_mode = RX_FREE;
	int         rx_tick = 0;
	int         cycle_cnt = 0;

	// normalizer shadow state
	logic [7:0]  path_mem [DEPTH];
	int unsigned out_idx = 0;
	int unsigned seg_start = 0;
	logic [15:0] last_pair = 16'h0000;
	upn_phase_t  nz_phase = PH_SKIP;
	bit          ovf = 1'b0;

	url_path_normalizer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.wr_en     (wr_en),
		.wr_pos    (wr_pos),
		.wr_char   (wr_char),
		.lead_slash(lead_slash),
		.path_len  (path_len),
		.done_res  (done_res),
		.overflow  (overflow)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic path_res_t normalize_byte(logic [7:0] c);
		path_res_t   r;
		int unsigned tok;
		int unsigned o;
		r = '0;
		if (nz_phase == PH_SKIP) begin
			if (c == CH_SPACE) begin
			end else if (c == CH_NUL) begin
				path_mem[0] = CH_SLASH;
				r.lead_slash = 1'b1;
				out_idx = 1;
				r.done_res = 1'b1;
			end else if (c == CH_SLASH) begin
				path_mem[0] = CH_SLASH;
				r.wr_en = 1'b1;
				r.wr_pos = '0;
				r.wr_char = c;
				out_idx = 1;
				seg_start = 0;
				last_pair = {CH_NUL, CH_SLASH};
				nz_phase = PH_PATH;
			end else begin
				path_mem[0] = CH_SLASH;
				path_mem[1] = c;
				r.lead_slash = 1'b1;
				r.wr_en = 1'b1;
				r.wr_pos = AW'(1);
				r.wr_char = c;
				out_idx = 2;
				seg_start = 0;
				last_pair = {CH_SLASH, c};
				nz_phase = PH_PATH;
			end
		end else begin
			if (c == CH_SLASH || c == CH_NUL) begin
				tok = out_idx - seg_start;
				if (tok == 3 && last_pair == PAIR_DOTDOT) begin
					o = seg_start;
					if (o > 0) begin
						o--;
						while (o > 0 && o < DEPTH && path_mem[o] != CH_SLASH)
							o--;
					end
					if (c == CH_NUL && o < DEPTH)
						o++;
					out_idx = o;
				end else if (tok == 1 || last_pair == PAIR_SLASHDOT) begin
					o = seg_start;
					if (c == CH_NUL && o < DEPTH)
						o++;
					out_idx = o;
				end
				seg_start = out_idx;
			end
			if (c == CH_NUL) begin
				r.done_res = 1'b1;
			end else begin
				if (out_idx < DEPTH) begin
					path_mem[out_idx] = c;
					r.wr_en = 1'b1;
					r.wr_pos = out_idx[AW-1:0];
					r.wr_char = c;
					out_idx++;
				end else begin
					ovf = 1'b1;
				end
				last_pair = {last_pair[7:0], c};
			end
		end
		r.path_len = out_idx[LW-1:0];
		r.overflow = ovf;
		if (r.done_res) begin
			nz_phase = PH_SKIP;
			out_idx = 0;
			seg_start = 0;
			last_pair = '0;
			ovf = 1'b0;
		end
		return r;
	endfunction

	task automatic push_byte(logic [7:0] c);
		pend_item_t p;
		p.ch = c;
		p.drain = 1'b0;
		pend_q.push_back(p);
		n_items++;
	endtask

	task automatic push_drain();
		pend_item_t p;
		p.ch = CH_NUL;
		p.drain = 1'b1;
		pend_q.push_back(p);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] name_byte();
		if ($urandom_range(0, 9) < 7)
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'($urandom_range(1, 255));
	endfunction

	// well-formed paths most of the time, raw noise otherwise
	task automatic add_random_path();
		int nseg;
		int kind;
		bit lead;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				push_byte(8'($urandom_range(1, 255)));
			push_byte(CH_NUL);
			return;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				push_byte(CH_SPACE);
		lead = ($urandom_range(0, 6) != 0);
		nseg = $urandom_range(0, 6);
		for (int i = 0; i < nseg; i++) begin
			if (i > 0 || lead)
				push_byte(CH_SLASH);
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				push_byte(CH_DOT);
			end else if (kind < 4) begin
				push_byte(CH_DOT);
				push_byte(CH_DOT);
			end else if (kind > 4) begin
				repeat ($urandom_range(1, 8))
					push_byte(name_byte());
			end
		end
		if ($urandom_range(0, 2) == 0)
			push_byte(CH_SLASH);
		push_byte(CH_NUL);
	endtask

	// path longer than the buffer
	task automatic add_long_path();
		int start;
		int kind;
		start = n_items;
		push_byte(CH_SLASH);
		while (n_items - start < DEPTH + 40) begin
			kind = $urandom_range(0, 19);
			if (kind < 2) begin
				push_text("..");
			end else if (kind == 2) begin
				push_byte(CH_DOT);
			end else begin
				repeat ($urandom_range(10, 40))
					push_byte(name_byte());
			end
			push_byte(CH_SLASH);
		end
		push_text("/..");
		push_byte(CH_NUL);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= CH_NUL;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(normalize_byte(ch));
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pend_q[0].drain) begin
					in_valid <= 1'b0;
					if (expected_q.size() == 0)
						void'(pend_q.pop_front());
				end else begin
					in_valid <= 1'b1;
					ch <= pend_q[0].ch;
					void'(pend_q.pop_front());
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no item pending");
					err_cnt++;
				end else begin
					check_field("wr_en", 16'(expected_q[0].wr_en), 16'(wr_en));
					check_field("wr_pos", 16'(expected_q[0].wr_pos), 16'(wr_pos));
					check_field("wr_char", 16'(expected_q[0].wr_char), 16'(wr_char));
					check_field("lead_slash", 16'(expected_q[0].lead_slash),
						16'(lead_slash));
					check_field("path_len", 16'(expected_q[0].path_len), 16'(path_len));
					check_field("done_res", 16'(expected_q[0].done_res), 16'(done_res));
					check_field("overflow", 16'(expected_q[0].overflow), 16'(overflow));
					void'(expected_q.pop_front());
				end
				res_cnt++;
			end
			rx_tick++;
			if (rx_tick % 97 == 0)
				rx_mode = 2'($urandom_range(0, 2));
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (res_cnt >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE: out_ready <= 1'b1;
					RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		bit long_done;
		long_done = 1'b0;
		#1 arst_n = 1'b0;
		push_byte(CH_NUL);
		push_text("  ");
		push_byte(CH_NUL);
		push_text(" a/./b/../c//");
		push_byte(CH_NUL);
		push_text("/..");
		push_byte(CH_NUL);
		push_byte(8'hFF);
		push_byte(CH_NUL);
		push_drain();
		while (n_items < RAND_TARGET) begin
			if (!long_done && n_items > LONG_AT) begin
				add_long_path();
				long_done = 1'b1;
			end else begin
				add_random_path();
			end
			if ($urandom_range(0, 60) == 0)
				push_drain();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pend_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
